// ----- rtl/bgiou_pkg.sv -----
package bgiou_pkg;

  typedef struct packed {
    logic valid;
    logic empty;
  } ctl_t;

endpackage

// ----- rtl/bgiou_front.sv -----
module bgiou_front
  import bgiou_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_load,
  input  logic [COORD_BITS-1:0]     first_x,
  input  logic [COORD_BITS-1:0]     first_y,
  input  logic [COORD_BITS-1:0]     first_width,
  input  logic [COORD_BITS-1:0]     first_height,
  input  logic [COORD_BITS-1:0]     second_x,
  input  logic [COORD_BITS-1:0]     second_y,
  input  logic [COORD_BITS-1:0]     second_width,
  input  logic [COORD_BITS-1:0]     second_height,
  output logic                      ready,
  input  logic                      take,
  output ctl_t                      out_ctl,
  output logic [2*COORD_BITS+1:0]   out_rem_iou,
  output logic [2*COORD_BITS+1:0]   out_den_iou,
  output logic                      out_q_iou,
  output logic [2*COORD_BITS+1:0]   out_rem_pen,
  output logic [2*COORD_BITS+1:0]   out_den_pen,
  output logic                      out_q_pen
);

  localparam int C  = COORD_BITS;
  localparam int EW = COORD_BITS + 1;
  localparam int DW = 2 * COORD_BITS + 2;

  logic [5:1] v_r;
  logic [6:1] en;

  // stage 1: edges
  logic [C-1:0]  ax0_r, ay0_r, bx0_r, by0_r, aw_r, ah_r, bw_r, bh_r;
  logic [EW-1:0] ax1_r, ay1_r, bx1_r, by1_r;
  // stage 2: overlap and hull sides
  logic [C-1:0]  iw_r, ih_r, aw2_r, ah2_r, bw2_r, bh2_r;
  logic [EW-1:0] hw_r, hh_r;
  logic [EW-1:0] ix0, ix1, iy0, iy1, hx0, hx1, hy0, hy1;
  logic [C-1:0]  iw_nxt, ih_nxt;
  // stage 3: areas
  logic [2*C-1:0] inter_r, area_a_r, area_b_r;
  logic [DW-1:0]  hull_r;
  // stage 4: union and hull gap
  logic [DW-1:0]  inter4_r, uni_r, gap_r, hull4_r;
  logic           empty4_r;
  logic [DW-1:0]  uni_nxt;
  // stage 5: leading quotient bit
  logic [DW-1:0]  rem_iou_r, den_iou_r, rem_pen_r, den_pen_r;
  logic           q_iou_r, q_pen_r, empty5_r;
  logic           ge_iou, ge_pen;

  always_comb begin
    en[6] = take;
    for (int k = 5; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign ready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_load;
      for (int k = 2; k <= 5; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ax0_r <= first_x;
      ay0_r <= first_y;
      bx0_r <= second_x;
      by0_r <= second_y;
      aw_r  <= first_width;
      ah_r  <= first_height;
      bw_r  <= second_width;
      bh_r  <= second_height;
      ax1_r <= {1'b0, first_x} + {1'b0, first_width};
      ay1_r <= {1'b0, first_y} + {1'b0, first_height};
      bx1_r <= {1'b0, second_x} + {1'b0, second_width};
      by1_r <= {1'b0, second_y} + {1'b0, second_height};
    end
  end

  always_comb begin
    ix0 = (ax0_r > bx0_r) ? {1'b0, ax0_r} : {1'b0, bx0_r};
    iy0 = (ay0_r > by0_r) ? {1'b0, ay0_r} : {1'b0, by0_r};
    ix1 = (ax1_r < bx1_r) ? ax1_r : bx1_r;
    iy1 = (ay1_r < by1_r) ? ay1_r : by1_r;
    hx0 = (ax0_r < bx0_r) ? {1'b0, ax0_r} : {1'b0, bx0_r};
    hy0 = (ay0_r < by0_r) ? {1'b0, ay0_r} : {1'b0, by0_r};
    hx1 = (ax1_r > bx1_r) ? ax1_r : bx1_r;
    hy1 = (ay1_r > by1_r) ? ay1_r : by1_r;
    iw_nxt = (ix1 > ix0) ? C'(ix1 - ix0) : '0;
    ih_nxt = (iy1 > iy0) ? C'(iy1 - iy0) : '0;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      iw_r  <= iw_nxt;
      ih_r  <= ih_nxt;
      hw_r  <= hx1 - hx0 + EW'(1);
      hh_r  <= hy1 - hy0 + EW'(1);
      aw2_r <= aw_r;
      ah2_r <= ah_r;
      bw2_r <= bw_r;
      bh2_r <= bh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      inter_r  <= iw_r * ih_r;
      area_a_r <= aw2_r * ah2_r;
      area_b_r <= bw2_r * bh2_r;
      hull_r   <= hw_r * hh_r;
    end
  end

  assign uni_nxt = DW'(area_a_r) + DW'(area_b_r) - DW'(inter_r);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      inter4_r <= DW'(inter_r);
      uni_r    <= uni_nxt;
      gap_r    <= hull_r - uni_nxt;
      hull4_r  <= hull_r;
      empty4_r <= (uni_nxt == '0);
    end
  end

  assign ge_iou = (inter4_r >= uni_r);
  assign ge_pen = (gap_r >= hull4_r);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      rem_iou_r <= ge_iou ? inter4_r - uni_r : inter4_r;
      den_iou_r <= uni_r;
      q_iou_r   <= ge_iou;
      rem_pen_r <= ge_pen ? gap_r - hull4_r : gap_r;
      den_pen_r <= hull4_r;
      q_pen_r   <= ge_pen;
      empty5_r  <= empty4_r;
    end
  end

  assign out_ctl.valid = v_r[5];
  assign out_ctl.empty = empty5_r;
  assign out_rem_iou   = rem_iou_r;
  assign out_den_iou   = den_iou_r;
  assign out_q_iou     = q_iou_r;
  assign out_rem_pen   = rem_pen_r;
  assign out_den_pen   = den_pen_r;
  assign out_q_pen     = q_pen_r;

endmodule

// ----- rtl/bgiou_div_cell.sv -----
module bgiou_div_cell
  import bgiou_pkg::*;
#(
  parameter int DW = 34,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ctl_t          in_ctl,
  input  logic [DW-1:0] in_rem_iou,
  input  logic [DW-1:0] in_den_iou,
  input  logic [QW-1:0] in_q_iou,
  input  logic [DW-1:0] in_rem_pen,
  input  logic [DW-1:0] in_den_pen,
  input  logic [QW-1:0] in_q_pen,
  output logic          ready,
  input  logic          take,
  output ctl_t          out_ctl,
  output logic [DW-1:0] out_rem_iou,
  output logic [DW-1:0] out_den_iou,
  output logic [QW-1:0] out_q_iou,
  output logic [DW-1:0] out_rem_pen,
  output logic [DW-1:0] out_den_pen,
  output logic [QW-1:0] out_q_pen
);

  logic          valid_r, empty_r;
  logic [DW-1:0] rem_iou_r, den_iou_r, rem_pen_r, den_pen_r;
  logic [QW-1:0] q_iou_r, q_pen_r;
  logic [DW:0]   sh_iou, sh_pen, df_iou, df_pen;
  logic          ge_iou, ge_pen;

  assign ready = !valid_r || take;

  // one restoring step per lane
  always_comb begin
    sh_iou = {in_rem_iou, 1'b0};
    sh_pen = {in_rem_pen, 1'b0};
    df_iou = sh_iou - {1'b0, in_den_iou};
    df_pen = sh_pen - {1'b0, in_den_pen};
    ge_iou = (sh_iou >= {1'b0, in_den_iou});
    ge_pen = (sh_pen >= {1'b0, in_den_pen});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      empty_r   <= in_ctl.empty;
      rem_iou_r <= ge_iou ? df_iou[DW-1:0] : sh_iou[DW-1:0];
      rem_pen_r <= ge_pen ? df_pen[DW-1:0] : sh_pen[DW-1:0];
      den_iou_r <= in_den_iou;
      den_pen_r <= in_den_pen;
      q_iou_r   <= {in_q_iou[QW-2:0], ge_iou};
      q_pen_r   <= {in_q_pen[QW-2:0], ge_pen};
    end
  end

  assign out_ctl.valid = valid_r;
  assign out_ctl.empty = empty_r;
  assign out_rem_iou   = rem_iou_r;
  assign out_den_iou   = den_iou_r;
  assign out_q_iou     = q_iou_r;
  assign out_rem_pen   = rem_pen_r;
  assign out_den_pen   = den_pen_r;
  assign out_q_pen     = q_pen_r;

endmodule

// ----- rtl/box_generalized_iou_unit.sv -----
// channel | ports   | word
// in      | in_*    | tdata: first_x, first_y, first_width, first_height,
//         |         |        second_x, second_y, second_width, second_height
// out     | out_*   | tdata: overlap_ratio, generalized_ratio; tuser: empty_union
//
// one box pair per cycle sustained while out_tready is high; a low out_tready stalls the pipeline
// five front stages (edges, sides, area products, union, leading quotient bit),
// then FRAC_BITS divider cells producing one quotient bit each, then the output register
// rst_n is synchronous and clears the valid bits only
// each stage moves when the next one is empty or moving, so bubbles close up under stall
module box_generalized_iou_unit
  import bgiou_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // first_x, first_y, first_width, first_height, second_x, second_y,
  // second_width, second_height
  input  logic [8*COORD_BITS-1:0]      in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // overlap_ratio, generalized_ratio, zero fill
  output logic [((2*FRAC_BITS+3+7)/8)*8-1:0] out_tdata,
  // empty_union
  output logic                         out_tuser
);

  localparam int C     = COORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int DW    = 2 * COORD_BITS + 2;
  localparam int QW    = FRAC_BITS + 1;
  localparam int GW    = FRAC_BITS + 2;
  localparam int OUT_W = ((2 * FRAC_BITS + 3 + 7) / 8) * 8;
  localparam int PAD_W = OUT_W - (2 * FRAC_BITS + 3);

  ctl_t          ctl     [0:F];
  logic [DW-1:0] rem_iou [0:F];
  logic [DW-1:0] den_iou [0:F];
  logic [QW-1:0] q_iou   [0:F];
  logic [DW-1:0] rem_pen [0:F];
  logic [DW-1:0] den_pen [0:F];
  logic [QW-1:0] q_pen   [0:F];
  logic          ld      [0:F];

  logic          q0_iou, q0_pen;
  logic          out_valid_r, out_empty_r;
  logic [QW-1:0] out_iou_r, iou_nxt;
  logic [GW-1:0] out_gen_r;

  bgiou_front #(
    .COORD_BITS(C)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_load      (in_tvalid),
    .first_x      (in_tdata[0*C +: C]),
    .first_y      (in_tdata[1*C +: C]),
    .first_width  (in_tdata[2*C +: C]),
    .first_height (in_tdata[3*C +: C]),
    .second_x     (in_tdata[4*C +: C]),
    .second_y     (in_tdata[5*C +: C]),
    .second_width (in_tdata[6*C +: C]),
    .second_height(in_tdata[7*C +: C]),
    .ready        (in_tready),
    .take         (ld[0]),
    .out_ctl      (ctl[0]),
    .out_rem_iou  (rem_iou[0]),
    .out_den_iou  (den_iou[0]),
    .out_q_iou    (q0_iou),
    .out_rem_pen  (rem_pen[0]),
    .out_den_pen  (den_pen[0]),
    .out_q_pen    (q0_pen)
  );

  assign q_iou[0] = QW'(q0_iou);
  assign q_pen[0] = QW'(q0_pen);

  for (genvar i = 0; i < F; i++) begin : g_cell
    bgiou_div_cell #(
      .DW(DW),
      .QW(QW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_ctl     (ctl[i]),
      .in_rem_iou (rem_iou[i]),
      .in_den_iou (den_iou[i]),
      .in_q_iou   (q_iou[i]),
      .in_rem_pen (rem_pen[i]),
      .in_den_pen (den_pen[i]),
      .in_q_pen   (q_pen[i]),
      .ready      (ld[i]),
      .take       (ld[i+1]),
      .out_ctl    (ctl[i+1]),
      .out_rem_iou(rem_iou[i+1]),
      .out_den_iou(den_iou[i+1]),
      .out_q_iou  (q_iou[i+1]),
      .out_rem_pen(rem_pen[i+1]),
      .out_den_pen(den_pen[i+1]),
      .out_q_pen  (q_pen[i+1])
    );
  end

  assign ld[F]   = !out_valid_r || out_tready;
  assign iou_nxt = ctl[F].empty ? '0 : q_iou[F];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld[F]) begin
      out_valid_r <= ctl[F].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[F]) begin
      out_iou_r   <= iou_nxt;
      out_gen_r   <= {1'b0, iou_nxt} - {1'b0, q_pen[F]};
      out_empty_r <= ctl[F].empty;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_gen_r, out_iou_r};
  assign out_tuser  = out_empty_r;

endmodule

// ----- test/tb_box_generalized_iou_unit.sv -----
module tb_box_generalized_iou_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS = 16;
  localparam int OUT_BITS = ((2 * FRAC_BITS + 3 + 7) / 8) * 8;
  localparam int LATENCY = FRAC_BITS + 6;
  localparam int LONG_STALL = 200;
  localparam int STALL_LIMIT = 5000;

  // packed so that first_x lands in the low bits of in_tdata
  typedef struct packed {
    logic [COORD_BITS-1:0] second_height;
    logic [COORD_BITS-1:0] second_width;
    logic [COORD_BITS-1:0] second_y;
    logic [COORD_BITS-1:0] second_x;
    logic [COORD_BITS-1:0] first_height;
    logic [COORD_BITS-1:0] first_width;
    logic [COORD_BITS-1:0] first_y;
    logic [COORD_BITS-1:0] first_x;
  } box_pair_t;

  typedef struct packed {
    logic [FRAC_BITS:0]   overlap_ratio;
    logic [FRAC_BITS+1:0] generalized_ratio;
    logic                 empty_union;
  } iou_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // first_x, first_y, first_width, first_height, second_x, second_y,
  // second_width, second_height
  logic [8*COORD_BITS-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // overlap_ratio, generalized_ratio, zero fill
  logic [OUT_BITS-1:0] out_tdata;
  // empty_union
  logic out_tuser;

  iou_result_t pending_ratios[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_requests = 0;
  int mismatches = 0;
  int pairs_sent = 0;
  int results_checked = 0;
  int empty_seen = 0;
  int quiet_cycles = 0;

  box_generalized_iou_unit #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic iou_result_t predict_ratios(input box_pair_t p);
    longint unsigned ax1, ay1, bx1, by1, lo, hi;
    longint unsigned iw, ih, inter, uni, hw, hh, hull, iou, pen;
    iou_result_t r;
    ax1 = 64'(p.first_x) + 64'(p.first_width);
    ay1 = 64'(p.first_y) + 64'(p.first_height);
    bx1 = 64'(p.second_x) + 64'(p.second_width);
    by1 = 64'(p.second_y) + 64'(p.second_height);
    lo = (p.first_x > p.second_x) ? 64'(p.first_x) : 64'(p.second_x);
    hi = (ax1 < bx1) ? ax1 : bx1;
    iw = (hi > lo) ? hi - lo : 0;
    lo = (p.first_y > p.second_y) ? 64'(p.first_y) : 64'(p.second_y);
    hi = (ay1 < by1) ? ay1 : by1;
    ih = (hi > lo) ? hi - lo : 0;
    inter = iw * ih;
    uni = 64'(p.first_width) * 64'(p.first_height)
        + 64'(p.second_width) * 64'(p.second_height) - inter;
    hw = ((ax1 > bx1) ? ax1 : bx1)
       - ((p.first_x < p.second_x) ? 64'(p.first_x) : 64'(p.second_x)) + 1;
    hh = ((ay1 > by1) ? ay1 : by1)
       - ((p.first_y < p.second_y) ? 64'(p.first_y) : 64'(p.second_y)) + 1;
    hull = hw * hh;
    // quotients truncate separately before the subtraction
    iou = (uni == 0) ? 0 : (inter << FRAC_BITS) / uni;
    pen = ((hull - uni) << FRAC_BITS) / hull;
    r.overlap_ratio = iou[FRAC_BITS:0];
    r.generalized_ratio = 18'(iou - pen);
    r.empty_union = (uni == 0);
    return r;
  endfunction

  function automatic box_pair_t make_pair(input int ax, ay, aw, ah, bx, by, bw, bh);
    box_pair_t p;
    p.first_x = 16'(ax);
    p.first_y = 16'(ay);
    p.first_width = 16'(aw);
    p.first_height = 16'(ah);
    p.second_x = 16'(bx);
    p.second_y = 16'(by);
    p.second_width = 16'(bw);
    p.second_height = 16'(bh);
    return p;
  endfunction

  function automatic box_pair_t random_pair();
    int kind, ax, ay, aw, ah, bx, by, bw, bh;
    kind = $urandom_range(9);
    ax = $urandom_range(65535);
    ay = $urandom_range(65535);
    aw = $urandom_range(400);
    ah = $urandom_range(400);
    bx = ax + $urandom_range(400) - 200;
    by = ay + $urandom_range(400) - 200;
    bw = $urandom_range(400);
    bh = $urandom_range(400);
    case (kind)
      0, 1: begin
        aw = $urandom_range(65535);
        ah = $urandom_range(65535);
        bx = $urandom_range(65535);
        by = $urandom_range(65535);
        bw = $urandom_range(65535);
        bh = $urandom_range(65535);
      end
      6: begin
        ax = $urandom_range(32767);
        ay = $urandom_range(32767);
        bx = $urandom_range(32767);
        by = $urandom_range(32767);
        aw = $urandom_range(65535, 16384);
        ah = $urandom_range(65535, 16384);
        bw = $urandom_range(65535, 16384);
        bh = $urandom_range(65535, 16384);
      end
      7: begin
        if ($urandom_range(1)) aw = 0;
        else ah = 0;
        if ($urandom_range(1)) bw = 0;
      end
      8: begin
        ax = $urandom_range(60000);
        ay = $urandom_range(60000);
        aw = $urandom_range(5000);
        ah = $urandom_range(5000);
        bx = ax + $urandom_range(aw);
        by = ay + $urandom_range(ah);
        bw = $urandom_range(ax + aw - bx);
        bh = $urandom_range(ay + ah - by);
      end
      9: begin
        bx = ax;
        by = ay;
        bw = aw;
        bh = ah;
      end
      default: ;
    endcase
    return make_pair(ax, ay, aw, ah, bx, by, bw, bh);
  endfunction

  // called just after a rising edge; leaves in_tvalid high after the word goes
  task automatic send_pair(input box_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= p;
    do @(posedge clk); while (!in_tready);
    pending_ratios.push_back(predict_ratios(p));
    pairs_sent++;
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_ratios.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_boxes();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_pair(make_pair(10, 20, 30, 40, 10, 20, 30, 40));
    // zero-area boxes, mostly with zero union
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(5, 5, 0, 0, 100, 100, 0, 0));
    send_pair(make_pair(0, 0, 10, 0, 0, 0, 10, 0));
    send_pair(make_pair('hffff, 'hffff, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(0, 0, 0, 50, 0, 0, 10, 10));
    // disjoint, touching, nested and partly overlapping
    send_pair(make_pair(0, 0, 10, 10, 20, 0, 10, 10));
    send_pair(make_pair(0, 0, 10, 10, 0, 30, 10, 10));
    send_pair(make_pair(0, 0, 10, 10, 10, 0, 10, 10));
    send_pair(make_pair(0, 0, 100, 100, 25, 25, 50, 50));
    send_pair(make_pair(0, 0, 10, 10, 5, 5, 10, 10));
    send_pair(make_pair(5, 5, 10, 10, 0, 0, 10, 10));
    // field extremes, bit patterns and unit boxes
    send_pair(make_pair('hffff, 'hffff, 'hffff, 'hffff, 'hffff, 'hffff, 'hffff, 'hffff));
    send_pair(make_pair(0, 0, 1, 1, 'hffff, 'hffff, 'hffff, 'hffff));
    send_pair(make_pair(0, 0, 'hffff, 'hffff, 0, 0, 'hffff, 'hffff));
    send_pair(make_pair(0, 0, 'hffff, 'hffff, 'h8000, 'h8000, 'hffff, 'hffff));
    send_pair(make_pair('haaaa, 'h5555, 'haaaa, 'h5555, 'h5555, 'haaaa, 'h5555, 'haaaa));
    send_pair(make_pair('h5555, 'haaaa, 'h5555, 'haaaa, 'haaaa, 'h5555, 'haaaa, 'h5555));
    send_pair(make_pair(7, 7, 1, 1, 7, 7, 1, 1));
    send_pair(make_pair(0, 0, 'hffff, 1, 0, 0, 1, 'hffff));
    wait_for_results();
  endtask

  task automatic test_random_boxes(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_pair(random_pair());
    wait_for_results();
  endtask

  // output held off long enough for the pipeline to fill and push back
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_requests++;
    repeat (60) send_pair(random_pair());
    wait_for_results();
  endtask

  always @(posedge clk) begin : receiver
    static int stall_left = 0;
    static int stalls_seen = 0;
    if (stalls_seen != stall_requests) begin
      stalls_seen = stall_requests;
      stall_left = LONG_STALL;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    iou_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.overlap_ratio = out_tdata[FRAC_BITS:0];
      got.generalized_ratio = out_tdata[2*FRAC_BITS+2:FRAC_BITS+1];
      got.empty_union = out_tuser;
      if (pending_ratios.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: iou %0d giou %0d empty %0b",
                   got.overlap_ratio, $signed(got.generalized_ratio), got.empty_union);
      end else begin
        want = pending_ratios.pop_front();
        results_checked++;
        if (want.empty_union) empty_seen++;
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at word %0d: iou %0d/%0d giou %0d/%0d empty %0b/%0b (exp/got)",
                     results_checked, want.overlap_ratio, got.overlap_ratio,
                     $signed(want.generalized_ratio), $signed(got.generalized_ratio),
                     want.empty_union, got.empty_union);
        end
      end
    end
  end

  initial begin : watchdog
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_boxes();
    test_random_boxes(110, 31, 74);
    test_output_stall();
    test_random_boxes(110, 74, 31);
    test_random_boxes(100, 0, 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (pending_ratios.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", pending_ratios.size());
    end
    $display("checked %0d of %0d box pairs, %0d with empty union", results_checked,
             pairs_sent, empty_seen);
    $display("directed extremes, random overlap mixes, three idle patterns, long output stall");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
